FILE: design/cvrp_pkg.sv
// Shared constants, payload types and codes of the nearest-neighbour route builder.
package cvrp_pkg;

    localparam int MAX_NODES    = 16;
    localparam int DIST_BITS    = 24;

    localparam int NODE_W       = 5;
    localparam int DIST_FIELD_W = 24;
    localparam int DEMAND_W     = 16;
    localparam int OP_W         = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam int IDX_W        = $clog2(MAX_NODES);
    localparam int ADDR_W       = 2 * IDX_W;
    localparam int DIST_W       = (DIST_BITS < DIST_FIELD_W) ? DIST_BITS : DIST_FIELD_W;

    localparam logic [OP_W-1:0] OP_LOAD_DIST   = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_DEMAND = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN         = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPOT_NODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 2'd2;

    localparam logic [NODE_W-1:0]   RST_NODE_COUNT = 5'd16;
    localparam logic [NODE_W-1:0]   RST_DEPOT_NODE = 5'd1;
    localparam logic [DEMAND_W-1:0] RST_CAPACITY   = 16'hFFFF;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [NODE_W-1:0]       from_node;
        logic [NODE_W-1:0]       to_node;
        logic [DIST_FIELD_W-1:0] distance;
        logic [DEMAND_W-1:0]     demand;
    } t_in_item;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              route_closed;
        logic              last;
        logic              error;
    } t_out_item;

    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   idx;
        logic [DEMAND_W-1:0] dem;
    } t_cand;

endpackage

FILE: design/cvrp_dist_ram.sv
// Simple dual-port distance RAM with registered read data.
module cvrp_dist_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 24
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/cvrp_best_unit.sv
// Shared compare unit that tracks the nearest fitting candidate of one row scan.
module cvrp_best_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  cvrp_pkg::t_cand            i_cand,
    input  logic [cvrp_pkg::DIST_W-1:0] i_dist,
    output cvrp_pkg::t_cand            o_best
);

    cvrp_pkg::t_cand               r_best;
    logic [cvrp_pkg::DIST_W-1:0]   r_dist;
    logic                          w_take;

    // strict compare keeps the lower index on a tie
    assign w_take = i_cand.valid && (!r_best.valid || (i_dist < r_dist));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best.valid <= 1'b0;
        end else if (i_clear) begin
            r_best.valid <= 1'b0;
        end else if (w_take) begin
            r_best <= i_cand;
            r_dist <= i_dist;
        end
    end

    assign o_best = r_best;

endmodule

FILE: design/cvrp_nearest_neighbour_routes_unit.sv
// Top level: load handling, route sequencer and result register of the route builder.
//
// Load items (distance or demand) are taken while idle and leave the input ready.
// A run item holds the input not ready until its last result is registered. Every result
// of a good configuration costs one row scan: distance RAM reads of node_count columns
// through the single read port, a last compare and a decision step, so a customer visit or
// a route closure costs one scan, plus any time the output side stalls. A run with
// K customers and R routes takes K + R row scans. A bad configuration goes through a
// fail state, which registers its error result once the output side can take it.
module cvrp_nearest_neighbour_routes_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  cvrp_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output cvrp_pkg::t_out_item              o_out_item,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cvrp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cvrp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_DECIDE,
        S_FAIL
    } t_state;

    localparam int NODE_W = cvrp_pkg::NODE_W;
    localparam int IDX_W  = cvrp_pkg::IDX_W;
    localparam int DEM_W  = cvrp_pkg::DEMAND_W;
    localparam int NMAX   = cvrp_pkg::MAX_NODES;

    t_state                       r_state, n_state;
    logic [NODE_W-1:0]            r_node_count, n_node_count;
    logic [NODE_W-1:0]            r_depot_node, n_depot_node;
    logic [DEM_W-1:0]             r_capacity, n_capacity;
    logic [NMAX-1:0]              r_visited, n_visited;
    logic [IDX_W-1:0]             r_cur, n_cur;
    logic [IDX_W-1:0]             r_col, n_col;
    logic [DEM_W-1:0]             r_rem, n_rem;
    logic [NODE_W-1:0]            r_left, n_left;
    logic                         r_added, n_added;
    logic                         r_out_valid, n_out_valid;
    cvrp_pkg::t_out_item          r_out, n_out;
    cvrp_pkg::t_cand              r_cand, n_cand;

    logic [DEM_W-1:0]             r_demand [NMAX];

    logic                         w_in_acc;
    logic                         w_emit_ok;
    logic                         w_clear;
    logic                         w_bad_cfg;
    logic                         w_from_ok;
    logic                         w_to_ok;
    logic                         w_dist_wr;
    logic                         w_dem_wr;
    logic                         w_last_col;
    logic [IDX_W-1:0]             w_depot_idx;
    logic [IDX_W-1:0]             w_from_idx;
    logic [IDX_W-1:0]             w_to_idx;
    logic [cvrp_pkg::DIST_W-1:0]  w_rd_dist;
    cvrp_pkg::t_cand              w_best;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_emit_ok = !r_out_valid || i_out_ready;

    assign w_from_ok  = (i_in_item.from_node != '0) &&
                        (i_in_item.from_node <= NODE_W'(NMAX));
    assign w_to_ok    = (i_in_item.to_node != '0) &&
                        (i_in_item.to_node <= NODE_W'(NMAX));
    assign w_from_idx = IDX_W'(i_in_item.from_node - NODE_W'(1));
    assign w_to_idx   = IDX_W'(i_in_item.to_node - NODE_W'(1));

    assign w_dist_wr = w_in_acc && (i_in_item.operation == cvrp_pkg::OP_LOAD_DIST) &&
                       w_from_ok && w_to_ok;
    assign w_dem_wr  = w_in_acc && (i_in_item.operation == cvrp_pkg::OP_LOAD_DEMAND) &&
                       w_from_ok;

    assign w_bad_cfg = (r_node_count < NODE_W'(2)) || (r_node_count > NODE_W'(NMAX)) ||
                       (r_depot_node == '0) || (r_depot_node > r_node_count);
    assign w_depot_idx = IDX_W'(r_depot_node - NODE_W'(1));
    assign w_last_col  = (NODE_W'(r_col) == (r_node_count - NODE_W'(1)));

    cvrp_dist_ram #(
        .ADDR_W (cvrp_pkg::ADDR_W),
        .DATA_W (cvrp_pkg::DIST_W)
    ) u_dist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_dist_wr),
        .i_wr_addr ({w_from_idx, w_to_idx}),
        .i_wr_data (cvrp_pkg::DIST_W'(i_in_item.distance)),
        .i_rd_addr ({r_cur, r_col}),
        .o_rd_data (w_rd_dist)
    );

    cvrp_best_unit u_best_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_clear),
        .i_cand  (r_cand),
        .i_dist  (w_rd_dist),
        .o_best  (w_best)
    );

    always_ff @(posedge i_clk) begin
        if (w_dem_wr) begin
            r_demand[w_from_idx] <= i_in_item.demand;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_node_count = r_node_count;
        n_depot_node = r_depot_node;
        n_capacity   = r_capacity;
        n_visited    = r_visited;
        n_cur        = r_cur;
        n_col        = r_col;
        n_rem        = r_rem;
        n_left       = r_left;
        n_added      = r_added;
        n_out        = r_out;
        n_out_valid  = i_out_ready ? 1'b0 : r_out_valid;
        n_cand.valid = 1'b0;
        n_cand.idx   = r_col;
        n_cand.dem   = r_demand[r_col];
        w_clear      = 1'b0;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                cvrp_pkg::CFG_NODE_COUNT: n_node_count = NODE_W'(i_cfg_data);
                cvrp_pkg::CFG_DEPOT_NODE: n_depot_node = NODE_W'(i_cfg_data);
                cvrp_pkg::CFG_CAPACITY:   n_capacity   = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in_item.operation == cvrp_pkg::OP_RUN)) begin
                    if (w_bad_cfg) begin
                        n_state = S_FAIL;
                    end else begin
                        n_visited = NMAX'(1) << w_depot_idx;
                        n_left    = r_node_count - NODE_W'(1);
                        n_rem     = r_capacity;
                        n_cur     = w_depot_idx;
                        n_added   = 1'b0;
                        n_col     = '0;
                        w_clear   = 1'b1;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_cand.valid = (r_col != r_cur) && !r_visited[r_col] &&
                               (r_demand[r_col] <= r_rem);
                n_col = r_col + IDX_W'(1);
                if (w_last_col) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (w_emit_ok) begin
                    n_out_valid = 1'b1;
                    n_col       = '0;
                    if (w_best.valid) begin
                        n_out     = '{node: NODE_W'(w_best.idx) + NODE_W'(1),
                                      route_closed: 1'b0, last: 1'b0, error: 1'b0};
                        n_visited = r_visited | (NMAX'(1) << w_best.idx);
                        n_rem     = r_rem - w_best.dem;
                        n_cur     = w_best.idx;
                        n_left    = r_left - NODE_W'(1);
                        n_added   = 1'b1;
                        w_clear   = 1'b1;
                        n_state   = S_SCAN;
                    end else if (!r_added) begin
                        n_out   = '{node: r_depot_node, route_closed: 1'b0,
                                    last: 1'b1, error: 1'b1};
                        n_state = S_IDLE;
                    end else begin
                        n_out = '{node: r_depot_node, route_closed: 1'b1,
                                  last: (r_left == '0), error: 1'b0};
                        if (r_left == '0) begin
                            n_state = S_IDLE;
                        end else begin
                            n_rem   = r_capacity;
                            n_cur   = w_depot_idx;
                            n_added = 1'b0;
                            w_clear = 1'b1;
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_FAIL: begin
                if (w_emit_ok) begin
                    n_out_valid = 1'b1;
                    n_out       = '{node: r_depot_node, route_closed: 1'b0,
                                    last: 1'b1, error: 1'b1};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= cvrp_pkg::RST_NODE_COUNT;
            r_depot_node <= cvrp_pkg::RST_DEPOT_NODE;
            r_capacity   <= cvrp_pkg::RST_CAPACITY;
            r_visited    <= '0;
            r_cur        <= '0;
            r_col        <= '0;
            r_rem        <= '0;
            r_left       <= '0;
            r_added      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cand.valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_node_count <= n_node_count;
            r_depot_node <= n_depot_node;
            r_capacity   <= n_capacity;
            r_visited    <= n_visited;
            r_cur        <= n_cur;
            r_col        <= n_col;
            r_rem        <= n_rem;
            r_left       <= n_left;
            r_added      <= n_added;
            r_out_valid  <= n_out_valid;
            r_cand.valid <= n_cand.valid;
        end
        r_out      <= n_out;
        r_cand.idx <= n_cand.idx;
        r_cand.dem <= n_cand.dem;
    end

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error) |-> r_out.last)
        else $error("error result without last");

    a_close_at_depot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.route_closed) |-> (r_out.node == r_depot_node))
        else $error("route closed away from depot");

    a_no_revisit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && w_emit_ok && w_best.valid) |-> !r_visited[w_best.idx])
        else $error("customer chosen twice");

    a_left_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && w_emit_ok && w_best.valid) |=>
        (r_left == $past(r_left) - NODE_W'(1)))
        else $error("clients left not decremented");

endmodule

FILE: bench/cvrp_route_checker.sv
`timescale 1ns / 1ps
// Route checker: predicts the visit stream of the nearest-neighbour route builder and compares it.
module cvrp_route_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  cvrp_pkg::t_in_item              i_in_item,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  cvrp_pkg::t_out_item             i_out_item,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [cvrp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cvrp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_mismatches,
    output int                              o_visits_due,
    output int                              o_runs,
    output int                              o_visits_seen
);

    localparam int PRINT_CAP = 100;
    localparam int NODE_W    = cvrp_pkg::NODE_W;
    localparam int DIST_W    = cvrp_pkg::DIST_W;
    localparam int DEM_W     = cvrp_pkg::DEMAND_W;
    localparam int MAX_NODES = cvrp_pkg::MAX_NODES;

    logic [DIST_W-1:0]   dist_mem [MAX_NODES*MAX_NODES];
    logic [DEM_W-1:0]    demand_mem [MAX_NODES];
    logic [NODE_W-1:0]   node_total;
    logic [NODE_W-1:0]   depot;
    logic [DEM_W-1:0]    capacity;
    cvrp_pkg::t_out_item visits_due [$];
    cvrp_pkg::t_out_item want;
    int                  mismatches = 0;
    int                  runs = 0;
    int                  visits_seen = 0;

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP) begin
            $display("%0t: route beat %0d: %s", $time, visits_seen, msg);
        end
        mismatches++;
    endtask

    function automatic void add_visit(input int unsigned node, input bit closed,
                                      input bit last_one, input bit err);
        cvrp_pkg::t_out_item v;
        v.node         = node[NODE_W-1:0];
        v.route_closed = closed;
        v.last         = last_one;
        v.error        = err;
        visits_due = {visits_due, v};
    endfunction

    function automatic void plan_routes();
        int unsigned          n;
        int unsigned          d;
        int unsigned          cur;
        int unsigned          best;
        int unsigned          left;
        int unsigned          added;
        int unsigned          c;
        logic [DIST_W-1:0]    best_dist;
        logic [DEM_W-1:0]     room;
        logic [MAX_NODES-1:0] taken;
        n = 32'(node_total);
        d = 32'(depot);
        if (n < 2 || n > MAX_NODES || d < 1 || d > n) begin
            add_visit(d, 1'b0, 1'b1, 1'b1);
            return;
        end
        taken = '0;
        taken[d-1] = 1'b1;
        left = n - 1;
        while (left > 0) begin
            room  = capacity;
            cur   = d;
            added = 0;
            best  = 1;
            while (best != 0) begin
                best = 0;
                best_dist = '0;
                for (c = 1; c <= n; c++) begin
                    if (c == cur || taken[c-1] || demand_mem[c-1] > room) continue;
                    if (best == 0 || dist_mem[(cur-1)*MAX_NODES + (c-1)] < best_dist) begin
                        best = c;
                        best_dist = dist_mem[(cur-1)*MAX_NODES + (c-1)];
                    end
                end
                if (best != 0) begin
                    taken[best-1] = 1'b1;
                    room = room - demand_mem[best-1];
                    cur = best;
                    left--;
                    added++;
                    add_visit(best, 1'b0, 1'b0, 1'b0);
                end
            end
            if (added == 0) begin
                add_visit(d, 1'b0, 1'b1, 1'b1);
                return;
            end
            add_visit(d, 1'b1, left == 0, 1'b0);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            node_total = cvrp_pkg::RST_NODE_COUNT;
            depot      = cvrp_pkg::RST_DEPOT_NODE;
            capacity   = cvrp_pkg::RST_CAPACITY;
            visits_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    cvrp_pkg::CFG_NODE_COUNT: node_total = i_cfg_data[NODE_W-1:0];
                    cvrp_pkg::CFG_DEPOT_NODE: depot      = i_cfg_data[NODE_W-1:0];
                    cvrp_pkg::CFG_CAPACITY:   capacity   = i_cfg_data[DEM_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_item.operation)
                    cvrp_pkg::OP_LOAD_DIST: begin
                        if (i_in_item.from_node >= 1 && i_in_item.from_node <= MAX_NODES &&
                            i_in_item.to_node >= 1 && i_in_item.to_node <= MAX_NODES) begin
                            dist_mem[(i_in_item.from_node - 1) * MAX_NODES +
                                     (i_in_item.to_node - 1)] = i_in_item.distance[DIST_W-1:0];
                        end
                    end
                    cvrp_pkg::OP_LOAD_DEMAND: begin
                        if (i_in_item.from_node >= 1 && i_in_item.from_node <= MAX_NODES) begin
                            demand_mem[i_in_item.from_node - 1] = i_in_item.demand;
                        end
                    end
                    cvrp_pkg::OP_RUN: begin
                        plan_routes();
                        runs++;
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                visits_seen++;
                if (visits_due.size() == 0) begin
                    report_mismatch($sformatf("beat with no visit due, node %0d",
                                              i_out_item.node));
                end else begin
                    want = visits_due.pop_front();
                    if (i_out_item.node !== want.node)
                        report_mismatch($sformatf("node %0d, expected %0d",
                                                  i_out_item.node, want.node));
                    if (i_out_item.route_closed !== want.route_closed)
                        report_mismatch($sformatf("route_closed %0b, expected %0b",
                                                  i_out_item.route_closed, want.route_closed));
                    if (i_out_item.last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  i_out_item.last, want.last));
                    if (i_out_item.error !== want.error)
                        report_mismatch($sformatf("error %0b, expected %0b",
                                                  i_out_item.error, want.error));
                end
            end
        end
        o_mismatches  <= mismatches;
        o_visits_due  <= visits_due.size();
        o_runs        <= runs;
        o_visits_seen <= visits_seen;
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, load and run stimulus, and verdict for the route builder.
module tb_top;

    localparam int NODE_W     = cvrp_pkg::NODE_W;
    localparam int DIST_FW    = cvrp_pkg::DIST_FIELD_W;
    localparam int DEM_W      = cvrp_pkg::DEMAND_W;
    localparam int CFG_DW     = cvrp_pkg::CFG_DATA_W;
    localparam int MAX_NODES  = cvrp_pkg::MAX_NODES;
    localparam int FILL_NODES = 8;

    localparam logic [cvrp_pkg::OP_W-1:0]      OP_SPARE      = 2'd3;
    localparam logic [cvrp_pkg::CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;
    localparam logic [DEM_W-1:0]               SOLO_DEMAND   = 16'd10;
    localparam int                             QUIET_LIMIT   = 4000;
    localparam int                             SETTLE_CYCLES = MAX_NODES + 4;
    localparam int                             STRAY_DIST    = 0;
    localparam int                             STRAY_DEMAND  = 1;
    localparam int                             STRAY_OP      = 2;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               in_valid  = 1'b0;
    logic                               in_ready;
    cvrp_pkg::t_in_item                 in_item   = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    cvrp_pkg::t_out_item                out_item;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [cvrp_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DW-1:0]                  cfg_data  = '0;

    int                    mismatches;
    int                    visits_due;
    int                    runs;
    int                    visits_seen;
    int unsigned           burst_left   = 0;
    int unsigned           quiet_cycles = 0;
    int unsigned           stall_left   = 0;
    int unsigned           settings     = 0;
    logic [DEM_W-1:0]      capacity     = cvrp_pkg::RST_CAPACITY;

    always #5 clk = ~clk;

    cvrp_nearest_neighbour_routes_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    cvrp_route_checker u_route_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_item    (out_item),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_visits_due  (visits_due),
        .o_runs        (runs),
        .o_visits_seen (visits_seen)
    );

    // Alternate ready and stall stretches of random length.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left == 0) begin
            out_ready  <= !out_ready;
            stall_left <= out_ready ? $urandom_range(0, 5) : $urandom_range(0, 24);
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles", QUIET_LIMIT);
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic cvrp_pkg::t_in_item random_item();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[$bits(cvrp_pkg::t_in_item)-1:0];
    endfunction

    function automatic logic [DIST_FW-1:0] rand_distance();
        logic [DIST_FW-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = '1;
            2, 3, 4: v = DIST_FW'($urandom_range(0, 3));
            default: v = DIST_FW'($urandom());
        endcase
        return v;
    endfunction

    function automatic logic [DEM_W-1:0] rand_demand();
        logic [DEM_W-1:0] v;
        case ($urandom_range(0, 15))
            0:       v = '0;
            1:       v = DEM_W'($urandom());
            2:       v = capacity;
            default: v = DEM_W'($urandom_range(0, capacity / 3));
        endcase
        return v;
    endfunction

    function automatic logic [NODE_W-1:0] stray_node();
        logic [NODE_W-1:0] v;
        v = $urandom_range(0, 1) ? '0 : NODE_W'($urandom_range(MAX_NODES + 1, 31));
        return v;
    endfunction

    task automatic send_item(input cvrp_pkg::t_in_item it);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic load_distance(input int unsigned from_n, input int unsigned to_n,
                                 input logic [DIST_FW-1:0] dist_val);
        cvrp_pkg::t_in_item it;
        it           = random_item();
        it.operation = cvrp_pkg::OP_LOAD_DIST;
        it.from_node = from_n[NODE_W-1:0];
        it.to_node   = to_n[NODE_W-1:0];
        it.distance  = dist_val;
        send_item(it);
    endtask

    task automatic load_demand(input int unsigned node, input logic [DEM_W-1:0] dem);
        cvrp_pkg::t_in_item it;
        it           = random_item();
        it.operation = cvrp_pkg::OP_LOAD_DEMAND;
        it.from_node = node[NODE_W-1:0];
        it.demand    = dem;
        send_item(it);
    endtask

    task automatic start_run();
        cvrp_pkg::t_in_item it;
        it           = random_item();
        it.operation = cvrp_pkg::OP_RUN;
        send_item(it);
    endtask

    task automatic send_stray(input int kind);
        cvrp_pkg::t_in_item it;
        it = random_item();
        case (kind)
            STRAY_DIST: begin
                it.operation = cvrp_pkg::OP_LOAD_DIST;
                if ($urandom_range(0, 1)) it.from_node = stray_node();
                else it.to_node = stray_node();
            end
            STRAY_DEMAND: begin
                it.operation = cvrp_pkg::OP_LOAD_DEMAND;
                it.from_node = stray_node();
            end
            default: it.operation = OP_SPARE;
        endcase
        send_item(it);
    endtask

    // Drain all due visits, then let a possible load finish.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (visits_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [cvrp_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DW-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic configure(input int unsigned n, input int unsigned d, input int unsigned cap);
        settle();
        write_reg(cvrp_pkg::CFG_NODE_COUNT, n);
        write_reg(cvrp_pkg::CFG_DEPOT_NODE, d);
        write_reg(cvrp_pkg::CFG_CAPACITY, cap);
        cfg_valid <= 1'b0;
        capacity = cap[DEM_W-1:0];
        settings++;
    endtask

    initial begin
        int unsigned n;
        int unsigned d;
        int unsigned cap;
        int unsigned lim;
        int unsigned k;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Fill the store corner of the first eight nodes, then build routes over them.
        configure(FILL_NODES, 1, 65535);
        for (int r = 1; r <= FILL_NODES; r++) begin
            for (int c = 1; c <= FILL_NODES; c++) load_distance(r, c, rand_distance());
        end
        for (int v = 1; v <= FILL_NODES; v++) load_demand(v, rand_demand());
        start_run();

        load_distance(1, 2, '1);
        load_distance(2, 3, '0);
        load_demand(5, '1);
        load_demand(6, '0);
        send_stray(STRAY_DIST);
        send_stray(STRAY_DEMAND);
        send_stray(STRAY_OP);
        start_run();

        // One customer per route over all nodes: only the depot row is scanned with a fit.
        configure(MAX_NODES, 1, SOLO_DEMAND);
        for (int c = FILL_NODES + 1; c <= MAX_NODES; c++) load_distance(1, c, rand_distance());
        for (int v = 1; v <= MAX_NODES; v++) load_demand(v, SOLO_DEMAND);
        start_run();

        // Ties at the depot row, then a customer that only the next route can take.
        configure(4, 4, 100);
        load_distance(4, 1, 7);
        load_distance(4, 2, 7);
        load_distance(4, 3, 7);
        load_demand(1, 60);
        load_demand(2, 50);
        load_demand(3, 40);
        start_run();

        configure(3, 1, 0);
        load_demand(2, 0);
        load_demand(3, 5);
        start_run();

        configure(2, 2, 65535);
        start_run();

        settle();
        write_reg(CFG_SPARE, $urandom());
        cfg_valid <= 1'b0;
        configure(1, 1, 500);
        start_run();
        configure(0, 0, 500);
        start_run();
        configure(17, 1, 500);
        start_run();
        configure(31, 31, 500);
        start_run();
        configure(5, 0, 500);
        start_run();
        configure(5, 6, 500);
        start_run();

        repeat (4) begin
            n = $urandom_range(2, FILL_NODES);
            d = $urandom_range(1, n);
            case ($urandom_range(0, 5))
                0:       cap = 0;
                1:       cap = 65535;
                2:       cap = $urandom_range(1, 200);
                default: cap = $urandom_range(0, 65535);
            endcase
            lim = n;
            if ($urandom_range(0, 7) == 0) begin
                lim = MAX_NODES;
                if ($urandom_range(0, 1)) n = $urandom_range(0, 1) ? $urandom_range(0, 1)
                                                                   : $urandom_range(17, 31);
                else d = $urandom_range(0, 1) ? 0 : $urandom_range(n + 1, 31);
            end
            configure(n, d, cap);
            repeat ($urandom_range(6, 10)) begin
                k = $urandom_range(0, 9);
                if (k < 5) load_distance($urandom_range(1, lim), $urandom_range(1, lim),
                                         rand_distance());
                else if (k < 7) load_demand($urandom_range(1, lim), rand_demand());
                else if (k < 8) send_stray($urandom_range(STRAY_DIST, STRAY_OP));
                else start_run();
            end
            start_run();
        end

        settle();
        $display("Ran %0d route builds under %0d register settings, %0d visit beats compared.",
                 runs, settings, visits_seen);
        if (mismatches == 0 && visits_due == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

FILE: cvrp_nearest_neighbour_routes_unit.f
design/cvrp_pkg.sv
design/cvrp_dist_ram.sv
design/cvrp_best_unit.sv
design/cvrp_nearest_neighbour_routes_unit.sv
bench/cvrp_route_checker.sv
bench/tb_top.sv
